>>> design/bcum_pkg.sv
// ----------------------------------------------------------------------------
// bcum_pkg
// Shared codes, constants and the job record for the bus-control master.
// ----------------------------------------------------------------------------
package bcum_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int POS_W        = 11;
  localparam logic [POS_W-1:0] POS_CAP = 11'd2047;

  // input commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_REPLY   = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_VERSION  = 4'd2;
  localparam logic [3:0] ST_BUS_ERR  = 4'd3;
  localparam logic [3:0] ST_FLAG     = 4'd4;
  localparam logic [3:0] ST_ID       = 4'd5;
  localparam logic [3:0] ST_LENGTH   = 4'd6;
  localparam logic [3:0] ST_ADDRESS  = 4'd7;
  localparam logic [3:0] ST_FRAME    = 4'd8;
  localparam logic [3:0] ST_TIMEOUT  = 4'd9;

  // actions
  localparam logic [1:0] ACT_DONE    = 2'd0;
  localparam logic [1:0] ACT_RETRY   = 2'd1;
  localparam logic [1:0] ACT_GIVE_UP = 2'd2;

  // header bytes
  localparam logic [7:0] VERSION_BYTE = 8'hFF;
  localparam logic [7:0] FLAG_READ    = 8'hC0;
  localparam logic [7:0] FLAG_WRITE   = 8'h80;
  localparam logic [7:0] FLAG_REPLY   = 8'h08;
  localparam logic [7:0] FLAG_BUS_ERR = 8'h01;

  localparam logic [2:0] MAX_ATTEMPTS_RESET = 3'd3;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        hdr;         // emit the request header
    logic        data_valid;  // emit one byte result
    logic [1:0]  data_kind;
    logic [7:0]  data_byte;
    logic        stat_valid;  // emit one status result
    logic [3:0]  status;
    logic [1:0]  action;
    logic        is_read;     // header fields
    logic [7:0]  id;
    logic [7:0]  length;
    logic [31:0] address;
  } job_t;

endpackage

>>> design/bcum_queue.sv
// ----------------------------------------------------------------------------
// bcum_queue
// Small job FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module bcum_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bcum_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bcum_pkg::job_t  head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bcum_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/bcum_front.sv
// ----------------------------------------------------------------------------
// bcum_front
// Accept input transfers, check reply bytes, keep the exchange state and
// queue the results each transfer causes as one job.
// ----------------------------------------------------------------------------
module bcum_front #(
  parameter int RX_LIMIT = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic                is_read,
  input  logic [31:0]         bus_address,
  input  logic [7:0]          byte_count,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  input  logic                full,
  output logic                push,
  output bcum_pkg::job_t      push_job
);

  localparam int POS_W    = bcum_pkg::POS_W;
  localparam int POS_STOP = (RX_LIMIT < 2047) ? RX_LIMIT : 2047;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_STOP);
  localparam logic [POS_W-1:0] HDR_LEN   = POS_W'(bcum_pkg::HEADER_BYTES);

  logic [2:0]       max_attempts;
  logic [7:0]       transaction_id;
  logic             expect_read;
  logic [7:0]       expect_length;
  logic [31:0]      expect_address;
  logic [POS_W-1:0] reply_position;
  logic [3:0]       first_error;
  logic [2:0]       attempts_used;

  logic             accept;
  logic [7:0]       want_flag;
  logic             take;
  logic [3:0]       hdr_err;
  logic [3:0]       first_error_next;
  logic [POS_W-1:0] reply_position_next;
  logic [3:0]       close_status;
  logic             closing;
  logic [3:0]       used;
  logic             give_up;
  logic [1:0]       close_action;

  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;
  assign want_flag = (expect_read ? bcum_pkg::FLAG_READ : bcum_pkg::FLAG_WRITE)
                     | bcum_pkg::FLAG_REPLY;
  assign take      = (reply_position < POS_LIMIT);

  // header check of one reply byte
  always_comb begin
    hdr_err = bcum_pkg::ST_OK;
    if (reply_position < HDR_LEN) begin
      case (reply_position[2:0])
        3'd0: if (data_byte != bcum_pkg::VERSION_BYTE) hdr_err = bcum_pkg::ST_VERSION;
        3'd1: if (data_byte != want_flag) begin
          hdr_err = ((data_byte & bcum_pkg::FLAG_BUS_ERR) != 8'd0) ?
                    bcum_pkg::ST_BUS_ERR : bcum_pkg::ST_FLAG;
        end
        3'd2: if (data_byte != transaction_id) hdr_err = bcum_pkg::ST_ID;
        3'd3: if (data_byte != expect_length) hdr_err = bcum_pkg::ST_LENGTH;
        3'd4: if (data_byte != expect_address[31:24]) hdr_err = bcum_pkg::ST_ADDRESS;
        3'd5: if (data_byte != expect_address[23:16]) hdr_err = bcum_pkg::ST_ADDRESS;
        3'd6: if (data_byte != expect_address[15:8]) hdr_err = bcum_pkg::ST_ADDRESS;
        3'd7: if (data_byte != expect_address[7:0]) hdr_err = bcum_pkg::ST_ADDRESS;
        default: hdr_err = bcum_pkg::ST_OK;
      endcase
    end
  end

  always_comb begin
    first_error_next    = first_error;
    reply_position_next = reply_position;
    if (take) begin
      reply_position_next = reply_position + 1'b1;
      if (first_error == bcum_pkg::ST_OK) begin
        first_error_next = hdr_err;
      end
    end
  end

  // status that closes an attempt
  always_comb begin
    if (cmd == bcum_pkg::CMD_TIMEOUT) begin
      close_status = bcum_pkg::ST_TIMEOUT;
    end else if (reply_position_next < HDR_LEN) begin
      close_status = bcum_pkg::ST_SHORT;
    end else if (first_error_next != bcum_pkg::ST_OK) begin
      close_status = first_error_next;
    end else if (reply_position_next != ({3'd0, expect_length} + HDR_LEN)) begin
      close_status = bcum_pkg::ST_FRAME;
    end else begin
      close_status = bcum_pkg::ST_OK;
    end
  end

  assign closing = (cmd == bcum_pkg::CMD_TIMEOUT) || ((cmd == bcum_pkg::CMD_REPLY) && last);
  assign used    = {1'b0, attempts_used} + 4'd1;
  assign give_up = (used >= {1'b0, max_attempts});

  always_comb begin
    if (close_status == bcum_pkg::ST_OK) begin
      close_action = bcum_pkg::ACT_DONE;
    end else if (give_up) begin
      close_action = bcum_pkg::ACT_GIVE_UP;
    end else begin
      close_action = bcum_pkg::ACT_RETRY;
    end
  end

  // build the job
  always_comb begin
    push_job            = '0;
    push_job.is_read    = is_read;
    push_job.id         = transaction_id;
    push_job.length     = byte_count;
    push_job.address    = bus_address;
    push_job.data_byte  = data_byte;
    push_job.status     = close_status;
    push_job.action     = close_action;
    push_job.stat_valid = closing;
    case (cmd)
      bcum_pkg::CMD_START: begin
        push_job.hdr = 1'b1;
      end
      bcum_pkg::CMD_WRITE: begin
        push_job.data_valid = 1'b1;
        push_job.data_kind  = bcum_pkg::KIND_TX;
      end
      bcum_pkg::CMD_REPLY: begin
        push_job.data_valid = take && (reply_position >= HDR_LEN) && expect_read;
        push_job.data_kind  = bcum_pkg::KIND_RX;
      end
      default: begin
        push_job.data_valid = 1'b0;
      end
    endcase
  end

  // drop reply bytes that cause no result
  assign push = accept && (push_job.hdr || push_job.data_valid || push_job.stat_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts   <= bcum_pkg::MAX_ATTEMPTS_RESET;
      transaction_id <= '0;
      expect_read    <= 1'b0;
      expect_length  <= '0;
      expect_address <= '0;
      reply_position <= '0;
      first_error    <= bcum_pkg::ST_OK;
      attempts_used  <= '0;
    end else begin
      if (cfg_we) begin
        max_attempts <= cfg_wdata;
      end
      if (accept) begin
        if (cmd == bcum_pkg::CMD_START) begin
          expect_read    <= is_read;
          expect_length  <= byte_count;
          expect_address <= bus_address;
          reply_position <= '0;
          first_error    <= bcum_pkg::ST_OK;
        end else if (closing) begin
          transaction_id <= transaction_id + 8'd1;
          reply_position <= '0;
          first_error    <= bcum_pkg::ST_OK;
          if (close_status == bcum_pkg::ST_OK || give_up) begin
            attempts_used <= '0;
          end else begin
            attempts_used <= used[2:0];
          end
        end else if (cmd == bcum_pkg::CMD_REPLY) begin
          reply_position <= reply_position_next;
          first_error    <= first_error_next;
        end
      end
    end
  end

endmodule

>>> design/bcum_back.sv
// ----------------------------------------------------------------------------
// bcum_back
// Pop jobs and emit their results through the output register.
// ----------------------------------------------------------------------------
module bcum_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  bcum_pkg::job_t  job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic            end_of_run,
  output logic [3:0]      status,
  output logic [1:0]      action
);

  logic [2:0] hdr_idx;
  logic       phase;      // set once the data byte of a reply job is out
  logic       load;
  logic [7:0] hdr_byte;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_eor;
  logic [3:0] res_status;
  logic [1:0] res_action;
  logic       job_done;

  assign load = !out_valid || !out_stall;

  always_comb begin
    case (hdr_idx)
      3'd0:    hdr_byte = bcum_pkg::VERSION_BYTE;
      3'd1:    hdr_byte = job.is_read ? bcum_pkg::FLAG_READ : bcum_pkg::FLAG_WRITE;
      3'd2:    hdr_byte = job.id;
      3'd3:    hdr_byte = job.length;
      3'd4:    hdr_byte = job.address[31:24];
      3'd5:    hdr_byte = job.address[23:16];
      3'd6:    hdr_byte = job.address[15:8];
      default: hdr_byte = job.address[7:0];
    endcase
  end

  always_comb begin
    res_status = bcum_pkg::ST_OK;
    res_action = bcum_pkg::ACT_DONE;
    if (job.hdr) begin
      res_kind = bcum_pkg::KIND_TX;
      res_byte = hdr_byte;
      res_eor  = (hdr_idx == 3'd7);
      job_done = res_eor;
    end else if (job.data_valid && !phase) begin
      res_kind = job.data_kind;
      res_byte = job.data_byte;
      res_eor  = !job.stat_valid;
      job_done = !job.stat_valid;
    end else begin
      res_kind   = bcum_pkg::KIND_STATUS;
      res_byte   = 8'd0;
      res_eor    = 1'b1;
      res_status = job.status;
      res_action = job.action;
      job_done   = 1'b1;
    end
  end

  assign pop = load && job_valid && job_done;

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      kind       <= res_kind;
      out_byte   <= res_byte;
      end_of_run <= res_eor;
      status     <= res_status;
      action     <= res_action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_idx   <= '0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= job_valid;
      if (job_valid) begin
        if (job_done) begin
          hdr_idx <= '0;
          phase   <= 1'b0;
        end else if (job.hdr) begin
          hdr_idx <= hdr_idx + 3'd1;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bus_control_udp_master.sv
// ----------------------------------------------------------------------------
// bus_control_udp_master
// Master side of a remote bus-control exchange: header out, reply checked.
// ----------------------------------------------------------------------------
// The first result of a transfer passes the job queue, then the output register.
// Throughput: one input transfer per cycle while the job queue has room; the
//   back emits one result per cycle while the output is not stalled, so a start
//   gives eight header results and a closing reply byte with data gives two.
// Reset (rst, synchronous): clears the exchange state, empties the queue and
//   sets max_attempts to 3.
module bus_control_udp_master #(
  parameter int RX_LIMIT    = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_attempts
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic        is_read,
  input  logic [31:0] bus_address,
  input  logic [7:0]  byte_count,
  input  logic [7:0]  data_byte,
  input  logic        last,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        end_of_run,
  output logic [3:0]  status,
  output logic [1:0]  action
);

  logic           push;
  bcum_pkg::job_t push_job;
  logic           full;
  logic           pop;
  logic           head_valid;
  bcum_pkg::job_t head_job;

  // Front: take each transfer, check reply bytes in order, update the id,
  // expectations and attempt count, and turn the transfer into at most one job.
  bcum_front #(
    .RX_LIMIT (RX_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .is_read     (is_read),
    .bus_address (bus_address),
    .byte_count  (byte_count),
    .data_byte   (data_byte),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .full        (full),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue: hold jobs so reply checking keeps going while a header drains.
  bcum_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: expand each job into its results, one per cycle while the output is
  // not stalled, into the output register.
  bcum_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (head_valid),
    .job        (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .end_of_run (end_of_run),
    .status     (status),
    .action     (action)
  );

endmodule

>>> dv/bus_control_udp_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_control_udp_master_tb
// Self-checking bench for the bus-control master. A scripted opening walks
// the header, payload, reply checks and attempt counting; random exchanges,
// mostly well-formed with corrupted, short, long and abandoned replies mixed
// in, follow under several attempt limits. Every result transfer is compared
// against an in-bench model of the exchange state.
// ----------------------------------------------------------------------------
module bus_control_udp_master_tb;

  localparam int RX_LIMIT = 2048;

  // one input transfer
  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_read;
    logic [31:0] addr;
    logic [7:0]  count;
    logic [7:0]  data;
    logic        last;
  } req_t;

  // one result transfer
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       eor;
    logic [3:0] st;
    logic [1:0] act;
  } result_t;

  // scripted row: typed rows carry the closing status and action by hand
  typedef struct {
    req_t       item;
    bit         typed;
    logic [3:0] st;
    logic [1:0] act;
  } step_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic        is_read;
  logic [31:0] bus_address;
  logic [7:0]  byte_count;
  logic [7:0]  data_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        end_of_run;
  logic [3:0]  status;
  logic [1:0]  action;

  bus_control_udp_master uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .is_read    (is_read),
    .bus_address(bus_address),
    .byte_count (byte_count),
    .data_byte  (data_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .end_of_run (end_of_run),
    .status     (status),
    .action     (action)
  );

  // --------------------------------------------------------------------------
  // Exchange model: mirror of the block's state, advanced once per accepted
  // input transfer.
  // --------------------------------------------------------------------------
  logic [2:0]  attempt_limit = bcum_pkg::MAX_ATTEMPTS_RESET;
  logic [7:0]  txn_id        = '0;
  logic        exp_read      = 1'b0;
  logic [7:0]  exp_len       = '0;
  logic [31:0] exp_addr      = '0;
  logic [10:0] rx_pos        = '0;
  logic [3:0]  first_err     = bcum_pkg::ST_OK;
  logic [2:0]  fails         = '0;

  // results still owed by the block, oldest first
  result_t awaited [$];

  int fail_count  = 0;
  int offered     = 0;
  int burst_left  = 0;
  int gap_max     = 0;
  bit hold_off    = 1'b0;

  step_row_t script [23];

  function automatic req_t rq(input logic [1:0] c, input logic rd, input logic [31:0] a,
                              input logic [7:0] n, input logic [7:0] d, input logic l);
    rq = '{c, rd, a, n, d, l};
  endfunction

  function automatic void owe(input logic [1:0] k, input logic [7:0] v, input logic e,
                              input logic [3:0] s, input logic [1:0] a);
    awaited.push_back('{k, v, e, s, a});
  endfunction

  // keep only the first header failure of a reply
  function automatic void note_err(input logic [3:0] code);
    if (first_err == bcum_pkg::ST_OK) first_err = code;
  endfunction

  // close the attempt; bump the id and pick done, retry or give up
  function automatic logic [1:0] close_attempt(input logic [3:0] st);
    int used;
    txn_id    = txn_id + 8'd1;
    rx_pos    = '0;
    first_err = bcum_pkg::ST_OK;
    if (st == bcum_pkg::ST_OK) begin
      fails = '0;
      return bcum_pkg::ACT_DONE;
    end
    used = int'(fails) + 1;
    if (used >= int'(attempt_limit)) begin
      fails = '0;
      return bcum_pkg::ACT_GIVE_UP;
    end
    fails = 3'(used);
    return bcum_pkg::ACT_RETRY;
  endfunction

  task automatic exchange_step(input req_t it);
    logic [1:0]  act;
    logic [3:0]  st;
    logic [10:0] p;
    logic [7:0]  want;
    int          sh;
    case (it.cmd)
      bcum_pkg::CMD_START: begin
        // record the expectations and emit the request header
        exp_read  = it.is_read;
        exp_addr  = it.addr;
        exp_len   = it.count;
        rx_pos    = '0;
        first_err = bcum_pkg::ST_OK;
        owe(bcum_pkg::KIND_TX, bcum_pkg::VERSION_BYTE, 1'b0, bcum_pkg::ST_OK,
            bcum_pkg::ACT_DONE);
        owe(bcum_pkg::KIND_TX, exp_read ? bcum_pkg::FLAG_READ : bcum_pkg::FLAG_WRITE,
            1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE);
        owe(bcum_pkg::KIND_TX, txn_id, 1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE);
        owe(bcum_pkg::KIND_TX, exp_len, 1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE);
        for (int k = 0; k < 4; k++)
          owe(bcum_pkg::KIND_TX, exp_addr[31-8*k -: 8], k == 3, bcum_pkg::ST_OK,
              bcum_pkg::ACT_DONE);
      end
      bcum_pkg::CMD_WRITE:
        owe(bcum_pkg::KIND_TX, it.data, 1'b1, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE);
      bcum_pkg::CMD_TIMEOUT: begin
        act = close_attempt(bcum_pkg::ST_TIMEOUT);
        owe(bcum_pkg::KIND_STATUS, 8'h00, 1'b1, bcum_pkg::ST_TIMEOUT, act);
      end
      default: begin
        p = rx_pos;
        // drop bytes past the datagram limit; the count saturates
        if (p < RX_LIMIT && p < bcum_pkg::POS_CAP) begin
          if (p < bcum_pkg::HEADER_BYTES) begin
            case (p)
              0: if (it.data != bcum_pkg::VERSION_BYTE) note_err(bcum_pkg::ST_VERSION);
              1: begin
                want = (exp_read ? bcum_pkg::FLAG_READ : bcum_pkg::FLAG_WRITE)
                       | bcum_pkg::FLAG_REPLY;
                if (it.data != want)
                  note_err((it.data & bcum_pkg::FLAG_BUS_ERR) != 0 ?
                           bcum_pkg::ST_BUS_ERR : bcum_pkg::ST_FLAG);
              end
              2: if (it.data != txn_id) note_err(bcum_pkg::ST_ID);
              3: if (it.data != exp_len) note_err(bcum_pkg::ST_LENGTH);
              default: begin
                sh = 8 * (7 - int'(p));
                if (it.data != exp_addr[sh +: 8]) note_err(bcum_pkg::ST_ADDRESS);
              end
            endcase
          end else if (exp_read) begin
            owe(bcum_pkg::KIND_RX, it.data, !it.last, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE);
          end
          rx_pos = p + 11'd1;
        end
        if (it.last) begin
          if (rx_pos < bcum_pkg::HEADER_BYTES)
            st = bcum_pkg::ST_SHORT;
          else if (first_err != bcum_pkg::ST_OK)
            st = first_err;
          else if (int'(rx_pos) - bcum_pkg::HEADER_BYTES != int'(exp_len))
            st = bcum_pkg::ST_FRAME;
          else
            st = bcum_pkg::ST_OK;
          act = close_attempt(st);
          owe(bcum_pkg::KIND_STATUS, 8'h00, 1'b1, st, act);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own. Alternate quiet stretches with
  // light and heavy stalling; on request, hold off for a long stretch so the
  // job queue fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin
    int stall_pct;
    int pattern_left;
    stall_pct    = 0;
    pattern_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest expectation.
  // --------------------------------------------------------------------------
  result_t seen;
  result_t want_res;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = '{kind, out_byte, end_of_run, status, action};
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind=%0d byte=%h eor=%0d st=%0d act=%0d",
                   seen.kind, seen.value, seen.eor, seen.st, seen.act);
      end else begin
        want_res = awaited.pop_front();
        if (seen !== want_res) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: expected kind=%0d byte=%h eor=%0d st=%0d act=%0d,",
                      " got kind=%0d byte=%h eor=%0d st=%0d act=%0d"},
                     want_res.kind, want_res.value, want_res.eor, want_res.st,
                     want_res.act, seen.kind, seen.value, seen.eor, seen.st, seen.act);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // offer one transfer in bursts with random gaps; predict once accepted
  task automatic offer(input req_t it);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    cmd         <= it.cmd;
    is_read     <= it.is_read;
    bus_address <= it.addr;
    byte_count  <= it.count;
    data_byte   <= it.data;
    last        <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    offered++;
    exchange_step(it);
  endtask

  // drop valid, wait for every owed result, then let the pipe drain
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_attempt_limit(input logic [2:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    attempt_limit = v;
    cfg_we <= 1'b0;
  endtask

  // one exchange: request, payload, then a reply that is mostly well formed
  task automatic random_exchange();
    req_t       it;
    logic [7:0] frame [$];
    int         pick;
    int         n_data;
    int         pos;
    int         n_send;
    if ($urandom_range(0, 99) < 12) begin
      // noise: any command with any content
      it = '{2'($urandom), 1'($urandom), $urandom, 8'($urandom), 8'($urandom), 1'($urandom)};
      offer(it);
      return;
    end
    pick = $urandom_range(0, 99);
    it.cmd     = bcum_pkg::CMD_START;
    it.is_read = 1'($urandom);
    it.addr    = $urandom;
    it.count   = pick < 70 ? 8'($urandom_range(0, 6)) :
                 pick < 92 ? 8'($urandom_range(7, 24)) : 8'($urandom);
    it.data    = $urandom;
    it.last    = $urandom;
    offer(it);

    // write payload passes straight through
    if (!it.is_read) begin
      for (int i = 0; i < int'(exp_len); i++) begin
        it = '{bcum_pkg::CMD_WRITE, 1'($urandom), $urandom, 8'($urandom), 8'($urandom),
               1'($urandom)};
        offer(it);
      end
    end

    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it = '{bcum_pkg::CMD_TIMEOUT, 1'($urandom), $urandom, 8'($urandom), 8'($urandom),
             1'($urandom)};
      offer(it);
      return;
    end
    // leave the request outstanding; the next start replaces it
    if (pick < 15) return;

    // build the reply the block should accept
    frame.push_back(bcum_pkg::VERSION_BYTE);
    frame.push_back((exp_read ? bcum_pkg::FLAG_READ : bcum_pkg::FLAG_WRITE)
                    | bcum_pkg::FLAG_REPLY);
    frame.push_back(txn_id);
    frame.push_back(exp_len);
    for (int k = 0; k < 4; k++) frame.push_back(exp_addr[31-8*k -: 8]);
    n_data = int'(exp_len);

    // corrupt one header byte now and then
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, 7);
      if (pos == 1)
        frame[1] = $urandom_range(0, 1) ? (frame[1] | bcum_pkg::FLAG_BUS_ERR) :
                                          (frame[1] ^ 8'h40);
      else
        frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
    end
    // wrong data length, or a reply cut inside its header
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      n_data++;
    end else if (pick < 16 && n_data > 0) begin
      n_data--;
    end else if (pick < 22) begin
      pos = $urandom_range(1, 7);
      while (frame.size() > pos) void'(frame.pop_back());
      n_data = 0;
    end
    for (int i = 0; i < n_data; i++) frame.push_back(8'($urandom));

    // occasionally abandon the reply midway; a new start cuts in
    n_send = frame.size();
    if (frame.size() > 1 && $urandom_range(0, 99) < 5)
      n_send = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < n_send; i++) begin
      it = '{bcum_pkg::CMD_REPLY, 1'($urandom), $urandom, 8'($urandom), frame[i],
             i == frame.size() - 1};
      offer(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [2:0] plan [5];
    int         phase_start;

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    cmd         <= bcum_pkg::CMD_START;
    is_read     <= 1'b0;
    bus_address <= '0;
    byte_count  <= '0;
    data_byte   <= '0;
    last        <= 1'b0;

    // scripted opening under the reset attempt limit of three
    script = '{
      // nothing outstanding: judge against the reset expectations
      '{rq(bcum_pkg::CMD_TIMEOUT, 1'b0, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b1, bcum_pkg::ST_TIMEOUT, bcum_pkg::ACT_RETRY},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b1, bcum_pkg::ST_SHORT,   bcum_pkg::ACT_RETRY},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'hFF, 1'b1),
        1'b1, bcum_pkg::ST_SHORT,   bcum_pkg::ACT_GIVE_UP},
      // extremes of the request, last ignored outside a reply
      '{rq(bcum_pkg::CMD_START,   1'b1, 32'hFFFFFFFF, 8'hFF, 8'hFF, 1'b1),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_WRITE,   1'b0, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_WRITE,   1'b1, 32'hFFFFFFFF, 8'hFF, 8'hFF, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      // clean write exchange of zero length, id three
      '{rq(bcum_pkg::CMD_START,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'hFF, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h88, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h03, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b1, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      // bus error flag, then a start cutting into the reply
      '{rq(bcum_pkg::CMD_START,   1'b1, 32'h12345678, 8'h01, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'hFF, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'hC9, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_START,   1'b1, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b0, bcum_pkg::ST_OK, bcum_pkg::ACT_DONE},
      '{rq(bcum_pkg::CMD_REPLY,   1'b0, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b1, bcum_pkg::ST_SHORT,   bcum_pkg::ACT_RETRY},
      '{rq(bcum_pkg::CMD_TIMEOUT, 1'b0, 32'h0,        8'h00, 8'h00, 1'b0),
        1'b1, bcum_pkg::ST_TIMEOUT, bcum_pkg::ACT_RETRY},
      '{rq(bcum_pkg::CMD_TIMEOUT, 1'b1, 32'h0,        8'h00, 8'h00, 1'b1),
        1'b1, bcum_pkg::ST_TIMEOUT, bcum_pkg::ACT_GIVE_UP}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    gap_max = 3;
    foreach (script[r]) begin
      offer(script[r].item);
      // typed rows override the model's closing status and action
      if (script[r].typed) begin
        awaited[awaited.size()-1].st  = script[r].st;
        awaited[awaited.size()-1].act = script[r].act;
      end
    end
    settle();

    // random phases: extremes of the limit, zero, and two middle values
    plan = '{3'd7, 3'd1, 3'd0, 3'd5, 3'd2};
    plan[4] = 3'($urandom_range(2, 6));
    foreach (plan[ph]) begin
      set_attempt_limit(plan[ph]);
      gap_max = (ph % 2 == 0) ? 6 : 0;
      // starve the receiver once so the queue fills and the input stalls
      if (ph == 0) hold_off = 1'b1;
      phase_start = offered;
      while (offered - phase_start < 30) random_exchange();
      settle();
    end

    repeat (20) @(posedge clk);
    fail_count += awaited.size();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
